// ===== sv/psc_pkg.sv =====
// ----------------------------------------------------------------------------
// psc_pkg: shared types and constants for pressure sensor compensation
// Payload structs, configuration register codes, scaling constants and the
// pipeline latency used by the compensation datapath.
// ----------------------------------------------------------------------------
package psc_pkg;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        REG_SENS_BASE         = 3'd0,
        REG_OFFSET_BASE       = 3'd1,
        REG_SENS_TEMP_COEFF   = 3'd2,
        REG_OFFSET_TEMP_COEFF = 3'd3,
        REG_REFERENCE_TEMP    = 3'd4,
        REG_TEMP_SLOPE        = 3'd5
    } psc_reg_t;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    // Temperature thresholds in 0.01 degC.
    localparam int TEMP_REF    = 2000;
    localparam int TEMP_FROZEN = -1500;

    // Truncating shifts (divisions by powers of two).
    localparam int SLOPE_SHIFT   = 23;
    localparam int OTC_SHIFT     = 6;
    localparam int STC_SHIFT     = 7;
    localparam int OFF_BASE_SH   = 17;
    localparam int SENS_BASE_SH  = 16;
    localparam int T2_COLD_SHIFT = 33;
    localparam int T2_WARM_SHIFT = 38;
    localparam int SQ_SHIFT      = 4;
    localparam int PROD_SHIFT    = 21;
    localparam int P_SHIFT       = 15;

    // Constant factors of the second-order correction.
    localparam int T2_COLD_MUL    = 3;
    localparam int T2_WARM_MUL    = 5;
    localparam int OFF2_LO_MUL    = 61;
    localparam int SENS2_LO_MUL   = 29;
    localparam int OFF2_COLD_MUL  = 17;
    localparam int SENS2_COLD_MUL = 9;

    // Split point of the pressure sensitivity for the partial products.
    localparam int SENS_W    = 42;
    localparam int SENS_LO_W = 21;

    // Register ranks from an accepted transaction to its result strobe.
    localparam int PSC_LATENCY = 9;

    typedef struct packed {
        logic [23:0] raw_pressure;
        logic [23:0] raw_temperature;
    } psc_sample_t;

    typedef struct packed {
        logic signed [18:0] temp_centi;
        logic signed [31:0] pressure_centi;
        logic               error_flag;
    } psc_result_t;

    typedef struct packed {
        logic [15:0] sens_base;
        logic [15:0] offset_base;
        logic [15:0] sens_temp_coeff;
        logic [15:0] offset_temp_coeff;
        logic [15:0] reference_temp;
        logic [15:0] temp_slope;
    } psc_cfg_t;

    // Handoff from the temperature section to the pressure section.
    typedef struct packed {
        logic                      err;
        logic [23:0]               raw_pressure;
        logic signed [18:0]        temp_centi;
        logic signed [43:0]        offset;
        logic signed [SENS_W-1:0]  sens;
    } psc_coef_t;

endpackage

// ===== sv/psc_front.sv =====
// ----------------------------------------------------------------------------
// psc_front: temperature and coefficient pipeline
// Five stages: temperature difference, products against dT, first-order
// temperature and linear coefficients, squared deviations, and the
// second-order offset and sensitivity terms.
// ----------------------------------------------------------------------------
module psc_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  psc_pkg::psc_sample_t  sample,
    input  psc_pkg::psc_cfg_t     cfg,
    output logic                  out_valid,
    output psc_pkg::psc_coef_t    coef
);
    import psc_pkg::*;

    // Stage 1: dT and zero-reading check.
    logic signed [25:0] dt_wide;
    logic               s1_valid_reg, s1_err_reg;
    logic [23:0]        s1_d1_reg;
    logic signed [24:0] s1_dt_reg;

    assign dt_wide = $signed({2'b00, sample.raw_temperature})
                   - $signed({2'b00, cfg.reference_temp, 8'h00});

    // Stage 2: products against dT.
    logic signed [41:0] slope_prod, otc_prod, stc_prod;
    logic signed [49:0] dtsq_full;
    logic               s2_valid_reg, s2_err_reg;
    logic [23:0]        s2_d1_reg;
    logic signed [41:0] s2_slope_reg, s2_otc_reg, s2_stc_reg;
    logic [48:0]        s2_dtsq_reg;

    assign slope_prod = s1_dt_reg * $signed({1'b0, cfg.temp_slope});
    assign otc_prod   = s1_dt_reg * $signed({1'b0, cfg.offset_temp_coeff});
    assign stc_prod   = s1_dt_reg * $signed({1'b0, cfg.sens_temp_coeff});
    assign dtsq_full  = s1_dt_reg * s1_dt_reg;

    // Stage 3: first-order temperature, T2 candidates, linear coefficients.
    logic signed [41:0] slope_bias, otc_bias, stc_bias;
    logic signed [41:0] slope_q, otc_q, stc_q;
    logic signed [19:0] temp_next;
    logic [50:0]        dtsq_x3;
    logic [51:0]        dtsq_x5;
    logic signed [37:0] off_lin_next;
    logic signed [36:0] sens_lin_next;
    logic               s3_valid_reg, s3_err_reg;
    logic [23:0]        s3_d1_reg;
    logic signed [19:0] s3_temp_reg;
    logic [16:0]        s3_t2c_reg;
    logic [12:0]        s3_t2w_reg;
    logic signed [37:0] s3_off_lin_reg;
    logic signed [36:0] s3_sens_lin_reg;

    // Adding the divisor minus one to negative values makes the shift
    // truncate toward zero.
    assign slope_bias = s2_slope_reg[41] ? (42'sd1 <<< SLOPE_SHIFT) - 42'sd1 : 42'sd0;
    assign otc_bias   = s2_otc_reg[41] ? (42'sd1 <<< OTC_SHIFT) - 42'sd1 : 42'sd0;
    assign stc_bias   = s2_stc_reg[41] ? (42'sd1 <<< STC_SHIFT) - 42'sd1 : 42'sd0;
    assign slope_q    = (s2_slope_reg + slope_bias) >>> SLOPE_SHIFT;
    assign otc_q      = (s2_otc_reg + otc_bias) >>> OTC_SHIFT;
    assign stc_q      = (s2_stc_reg + stc_bias) >>> STC_SHIFT;
    assign temp_next  = $signed(slope_q[19:0]) + 20'(TEMP_REF);

    assign dtsq_x3 = 51'(s2_dtsq_reg) * 51'(T2_COLD_MUL);
    assign dtsq_x5 = 52'(s2_dtsq_reg) * 52'(T2_WARM_MUL);

    assign off_lin_next  = $signed({5'b0, cfg.offset_base, {OFF_BASE_SH{1'b0}}})
                         + $signed(otc_q[37:0]);
    assign sens_lin_next = $signed({5'b0, cfg.sens_base, {SENS_BASE_SH{1'b0}}})
                         + $signed(stc_q[36:0]);

    // Stage 4: deviations from the thresholds and their squares.
    logic signed [20:0] lo_dev, cold_dev, temp_out;
    logic signed [41:0] lo_sq_full, cold_sq_full;
    logic [16:0]        t2_sel;
    logic               s4_valid_reg, s4_err_reg, s4_warm_reg, s4_frozen_reg;
    logic [23:0]        s4_d1_reg;
    logic [35:0]        s4_lo_sq_reg, s4_cold_sq_reg;
    logic signed [18:0] s4_temp_reg;
    logic signed [37:0] s4_off_lin_reg;
    logic signed [36:0] s4_sens_lin_reg;

    assign lo_dev       = 21'(s3_temp_reg) - 21'(TEMP_REF);
    assign cold_dev     = 21'(s3_temp_reg) - 21'(TEMP_FROZEN);
    assign lo_sq_full   = lo_dev * lo_dev;
    assign cold_sq_full = cold_dev * cold_dev;
    assign t2_sel       = lo_dev[20] ? s3_t2c_reg : 17'(s3_t2w_reg);
    assign temp_out     = 21'(s3_temp_reg) - $signed({4'b0, t2_sel});

    // Stage 5: second-order terms folded into offset and sensitivity.
    logic [41:0]        off2_lo, off2_cold, off2;
    logic [40:0]        sens2_lo, sens2_cold, sens2;
    logic signed [43:0] off_next;
    logic signed [41:0] sens_next;
    logic               out_valid_reg;
    psc_coef_t          coef_reg;

    assign off2_lo    = (42'(s4_lo_sq_reg) * 42'(OFF2_LO_MUL)) >> SQ_SHIFT;
    assign off2_cold  = 42'(s4_cold_sq_reg) * 42'(OFF2_COLD_MUL);
    assign sens2_lo   = (41'(s4_lo_sq_reg) * 41'(SENS2_LO_MUL)) >> SQ_SHIFT;
    assign sens2_cold = 41'(s4_cold_sq_reg) * 41'(SENS2_COLD_MUL);

    always_comb
    begin
        off2  = '0;
        sens2 = '0;
        if (!s4_warm_reg)
        begin
            off2  = off2_lo + (s4_frozen_reg ? off2_cold : 42'd0);
            sens2 = sens2_lo + (s4_frozen_reg ? sens2_cold : 41'd0);
        end
    end

    assign off_next  = 44'(s4_off_lin_reg) - $signed({2'b0, off2});
    assign sens_next = 42'(s4_sens_lin_reg) - $signed({1'b0, sens2});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= in_valid;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            s4_valid_reg  <= s3_valid_reg;
            out_valid_reg <= s4_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_err_reg <= (sample.raw_pressure == '0) || (sample.raw_temperature == '0);
        s1_d1_reg  <= sample.raw_pressure;
        s1_dt_reg  <= dt_wide[24:0];

        s2_err_reg   <= s1_err_reg;
        s2_d1_reg    <= s1_d1_reg;
        s2_slope_reg <= slope_prod;
        s2_otc_reg   <= otc_prod;
        s2_stc_reg   <= stc_prod;
        s2_dtsq_reg  <= dtsq_full[48:0];

        s3_err_reg      <= s2_err_reg;
        s3_d1_reg       <= s2_d1_reg;
        s3_temp_reg     <= temp_next;
        s3_t2c_reg      <= 17'(dtsq_x3 >> T2_COLD_SHIFT);
        s3_t2w_reg      <= 13'(dtsq_x5 >> T2_WARM_SHIFT);
        s3_off_lin_reg  <= off_lin_next;
        s3_sens_lin_reg <= sens_lin_next;

        s4_err_reg      <= s3_err_reg;
        s4_d1_reg       <= s3_d1_reg;
        s4_warm_reg     <= !lo_dev[20];
        s4_frozen_reg   <= cold_dev[20];
        s4_lo_sq_reg    <= lo_sq_full[35:0];
        s4_cold_sq_reg  <= cold_sq_full[35:0];
        s4_temp_reg     <= temp_out[18:0];
        s4_off_lin_reg  <= s3_off_lin_reg;
        s4_sens_lin_reg <= s3_sens_lin_reg;

        coef_reg.err          <= s4_err_reg;
        coef_reg.raw_pressure <= s4_d1_reg;
        coef_reg.temp_centi   <= s4_temp_reg;
        coef_reg.offset       <= off_next;
        coef_reg.sens         <= sens_next;
    end

    assign out_valid = out_valid_reg;
    assign coef      = coef_reg;

    // A temperature cannot be both at or above 20 degC and below -15 degC.
    a_region_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        s4_valid_reg |-> !(s4_warm_reg && s4_frozen_reg))
        else $error("psc_front: warm and frozen regions both flagged");

endmodule

// ===== sv/psc_press.sv =====
// ----------------------------------------------------------------------------
// psc_press: pressure pipeline
// Multiplies the raw pressure by the sensitivity as two partial products,
// scales and removes the offset, and registers the final result.
// ----------------------------------------------------------------------------
module psc_press (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  psc_pkg::psc_coef_t    coef,
    output logic                  done,
    output psc_pkg::psc_result_t  result
);
    import psc_pkg::*;

    // Stage 6: partial products of the raw pressure with the sensitivity.
    logic [44:0]        pp_lo;
    logic signed [45:0] pp_hi;
    logic               s6_valid_reg, s6_err_reg;
    logic [44:0]        s6_pp_lo_reg;
    logic signed [45:0] s6_pp_hi_reg;
    logic signed [43:0] s6_offset_reg;
    logic signed [18:0] s6_temp_reg;

    assign pp_lo = 45'(coef.raw_pressure) * 45'(coef.sens[SENS_LO_W-1:0]);
    assign pp_hi = $signed({1'b0, coef.raw_pressure})
                 * $signed(coef.sens[SENS_W-1:SENS_LO_W]);

    // Stage 7: full product.
    logic signed [66:0] prod;
    logic               s7_valid_reg, s7_err_reg;
    logic signed [66:0] s7_prod_reg;
    logic signed [43:0] s7_offset_reg;
    logic signed [18:0] s7_temp_reg;

    assign prod = (67'(s6_pp_hi_reg) <<< SENS_LO_W) + $signed({22'b0, s6_pp_lo_reg});

    // Stage 8: truncating scale and offset removal.
    logic signed [66:0] prod_bias, prod_q;
    logic signed [46:0] diff;
    logic               s8_valid_reg, s8_err_reg;
    logic signed [46:0] s8_diff_reg;
    logic signed [18:0] s8_temp_reg;

    assign prod_bias = s7_prod_reg[66] ? (67'sd1 <<< PROD_SHIFT) - 67'sd1 : 67'sd0;
    assign prod_q    = (s7_prod_reg + prod_bias) >>> PROD_SHIFT;
    assign diff      = 47'(prod_q) - 47'(s7_offset_reg);

    // Output stage: final truncating scale; a zero reading forces zeros.
    logic signed [46:0] diff_bias, p_q;
    logic               done_reg;
    psc_result_t        result_reg, result_next;

    assign diff_bias = s8_diff_reg[46] ? (47'sd1 <<< P_SHIFT) - 47'sd1 : 47'sd0;
    assign p_q       = (s8_diff_reg + diff_bias) >>> P_SHIFT;

    always_comb
    begin
        result_next.temp_centi     = s8_temp_reg;
        result_next.pressure_centi = $signed(p_q[31:0]);
        result_next.error_flag     = 1'b0;
        if (s8_err_reg)
        begin
            result_next.temp_centi     = '0;
            result_next.pressure_centi = '0;
            result_next.error_flag     = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s6_valid_reg <= 1'b0;
            s7_valid_reg <= 1'b0;
            s8_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            s6_valid_reg <= in_valid;
            s7_valid_reg <= s6_valid_reg;
            s8_valid_reg <= s7_valid_reg;
            done_reg     <= s8_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s6_err_reg    <= coef.err;
        s6_pp_lo_reg  <= pp_lo;
        s6_pp_hi_reg  <= pp_hi;
        s6_offset_reg <= coef.offset;
        s6_temp_reg   <= coef.temp_centi;

        s7_err_reg    <= s6_err_reg;
        s7_prod_reg   <= prod;
        s7_offset_reg <= s6_offset_reg;
        s7_temp_reg   <= s6_temp_reg;

        s8_err_reg  <= s7_err_reg;
        s8_diff_reg <= diff;
        s8_temp_reg <= s7_temp_reg;

        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

// ===== sv/pressure_sensor_compensation.sv =====
// ----------------------------------------------------------------------------
// pressure_sensor_compensation: barometric sensor compensation
// Turns raw 24-bit pressure and temperature conversions into temperature in
// 0.01 degC and pressure in 0.01 mbar, with second-order correction.
//
// Usage:
//   Load the six calibration words through cfg_write/cfg_index/cfg_data while
//   no transaction is in flight; a write to an index above 5 is ignored.
//   A transaction is accepted at a clock edge where start is high and busy is
//   low. busy stays low: the nine-stage pipeline takes one raw pair every
//   cycle, so throughput is one transaction per clock.
//   Each result appears on result for exactly one cycle with done high, in
//   acceptance order. The receiver cannot stall the block and must take
//   every result as it comes.
//   A raw reading of zero returns error_flag set and zero outputs.
//   Reset clears the pipeline valid bits and all calibration words to zero;
//   no result is pending after reset.
// ----------------------------------------------------------------------------
module pressure_sensor_compensation (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  psc_pkg::psc_sample_t                sample,
    input  logic                                cfg_write,
    input  logic [psc_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [psc_pkg::CFG_DATA_W-1:0]      cfg_data,
    output logic                                done,
    output psc_pkg::psc_result_t                result
);
    import psc_pkg::*;

    logic       accepted;
    logic       coef_valid;
    psc_coef_t  coef;
    psc_cfg_t   cfg_reg, cfg_next;

    assign busy     = 1'b0;
    assign accepted = start && !busy;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                REG_SENS_BASE:         cfg_next.sens_base         = cfg_data;
                REG_OFFSET_BASE:       cfg_next.offset_base       = cfg_data;
                REG_SENS_TEMP_COEFF:   cfg_next.sens_temp_coeff   = cfg_data;
                REG_OFFSET_TEMP_COEFF: cfg_next.offset_temp_coeff = cfg_data;
                REG_REFERENCE_TEMP:    cfg_next.reference_temp    = cfg_data;
                REG_TEMP_SLOPE:        cfg_next.temp_slope        = cfg_data;
                default:               cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    psc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accepted),
        .sample    (sample),
        .cfg       (cfg_reg),
        .out_valid (coef_valid),
        .coef      (coef)
    );

    psc_press u_press (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (coef_valid),
        .coef     (coef),
        .done     (done),
        .result   (result)
    );

    // Every accepted transaction yields its result after the fixed latency.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        accepted |-> ##PSC_LATENCY done)
        else $error("result missing after pipeline latency");

    // No result strobe without a matching transaction.
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accepted, PSC_LATENCY))
        else $error("result strobe without accepted transaction");

    // A zero pressure reading must come back flagged.
    a_zero_flagged: assert property (@(posedge clk) disable iff (!rst_n)
        accepted && (sample.raw_pressure == '0) |-> ##PSC_LATENCY result.error_flag)
        else $error("zero raw pressure not flagged");

    // Flagged results carry zero values.
    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.error_flag |->
            (result.temp_centi == '0) && (result.pressure_centi == '0))
        else $error("error result with nonzero values");

endmodule

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// tb: self-checking testbench for pressure_sensor_compensation
// Drives raw pressure/temperature pairs through the command port under several
// calibration settings and sender idling patterns. Every result is checked
// field by field against a typed-in value or the in-line second-order model.
// ----------------------------------------------------------------------------
module tb;
    import psc_pkg::*;

    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int ITEMS_PER_PHASE = 133;
    localparam int REPORT_LIMIT    = 10;
    localparam int PHASE_COUNT     = 7;

    // Indexes past the last calibration word; writes there must be ignored.
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_HI = 3'd7;

    localparam longint SLOPE_DIV   = 64'sd8388608;
    localparam longint T2_COLD_DIV = 64'sd8589934592;
    localparam longint T2_WARM_DIV = 64'sd274877906944;
    localparam longint PROD_DIV    = 64'sd2097152;
    localparam longint P_DIV       = 64'sd32768;
    localparam longint OFF_MUL     = 64'sd131072;
    localparam longint SENS_MUL    = 64'sd65536;

    localparam psc_cfg_t CAL_TYPICAL = {16'd40127, 16'd36924, 16'd23317,
                                        16'd23282, 16'd33464, 16'd28312};
    localparam psc_result_t RES_ZERO_READING = {19'sd0, 32'sd0, 1'b1};
    localparam psc_result_t RES_IDLE_CAL     = {19'sd2000, 32'sd0, 1'b0};
    localparam psc_result_t RES_IDLE_CAL_MAX = {-19'sd3119, 32'sd0, 1'b0};

    typedef enum {
        CAL_RANDOM,
        CAL_NOMINAL,
        CAL_MIXED,
        CAL_ALL_ONES,
        CAL_JITTER,
        CAL_ALL_ZERO
    } cal_kind_t;

    typedef struct {
        bit          load;
        psc_cfg_t    cal;
        psc_sample_t smp;
        bit          known;
        psc_result_t want;
    } dir_row_t;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        start     = 1'b0;
    psc_sample_t sample    = '0;
    logic        cfg_write = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;
    logic        busy;
    logic        done;
    psc_result_t result;

    // Typed-in expectation that travels with the transaction on the stimulus side.
    logic        fixed_valid  = 1'b0;
    psc_result_t fixed_result = '0;

    psc_cfg_t    cal_model = '0;
    psc_result_t pending_results [$];
    int          mismatches   = 0;
    int          stall_cycles = 0;

    always #10 clk = ~clk;

    pressure_sensor_compensation DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .sample    (sample),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .done      (done),
        .result    (result)
    );

    function automatic psc_result_t compensate(psc_sample_t s, psc_cfg_t c);
        longint d1, d2, dt, temp, t2, off2, sens2, off, sens, p, lo, cold;
        longint sb, ob, stc, otc, rt, slope;
        psc_result_t r;
        r = '0;
        d1 = s.raw_pressure;
        d2 = s.raw_temperature;
        if (d1 == 0 || d2 == 0)
        begin
            r.error_flag = 1'b1;
            return r;
        end
        sb    = c.sens_base;
        ob    = c.offset_base;
        stc   = c.sens_temp_coeff;
        otc   = c.offset_temp_coeff;
        rt    = c.reference_temp;
        slope = c.temp_slope;
        dt    = d2 - rt * 256;
        temp  = 2000 + (dt * slope) / SLOPE_DIV;
        if (temp < 2000)
        begin
            lo    = temp - 2000;
            t2    = (3 * (dt * dt)) / T2_COLD_DIV;
            off2  = (61 * lo * lo) / 16;
            sens2 = (29 * lo * lo) / 16;
            if (temp < -1500)
            begin
                cold  = temp + 1500;
                off2  = off2 + 17 * cold * cold;
                sens2 = sens2 + 9 * cold * cold;
            end
        end
        else
        begin
            t2    = (5 * (dt * dt)) / T2_WARM_DIV;
            off2  = 0;
            sens2 = 0;
        end
        off  = ob * OFF_MUL + (otc * dt) / 64 - off2;
        sens = sb * SENS_MUL + (stc * dt) / 128 - sens2;
        p    = ((d1 * sens) / PROD_DIV - off) / P_DIV;
        r.temp_centi     = 19'(temp - t2);
        r.pressure_centi = 32'(p);
        return r;
    endfunction

    function automatic psc_cfg_t pick_cal(cal_kind_t kind);
        psc_cfg_t c;
        c = {$urandom, $urandom, $urandom};
        case (kind)
            CAL_NOMINAL:  c = CAL_TYPICAL;
            CAL_ALL_ONES: c = '1;
            CAL_ALL_ZERO: c = '0;
            CAL_JITTER:   c = CAL_TYPICAL ^ (c & {6{16'h00FF}});
            CAL_MIXED:
                for (int i = 0; i < 6; i++)
                begin
                    case ($urandom_range(2))
                        0:       c[i*16 +: 16] = '0;
                        1:       c[i*16 +: 16] = '1;
                        default: ;
                    endcase
                end
            default: ;
        endcase
        return c;
    endfunction

    // Most temperatures land near the reference word so that the warm, cold and
    // frozen branches all see traffic whatever the calibration is.
    function automatic psc_sample_t draw_sample(psc_cfg_t c);
        psc_sample_t s;
        int unsigned pick;
        longint      t, span, off;
        s.raw_pressure    = 24'($urandom);
        s.raw_temperature = 24'($urandom);
        pick = $urandom_range(99);
        if (pick == 0)
            s = '0;
        else if (pick < 3)
        begin
            if ($urandom_range(1))
                s.raw_pressure = '0;
            else
                s.raw_temperature = '0;
        end
        else if (pick < 9)
        begin
            s.raw_pressure    = $urandom_range(1) ? 24'hFFFFFF : 24'd1;
            s.raw_temperature = $urandom_range(1) ? 24'hFFFFFF : 24'd1;
        end
        else if (pick >= 45)
        begin
            span = longint'(1) << $urandom_range(22, 4);
            off  = $urandom % span;
            if ($urandom_range(1))
                off = -off;
            t = c.reference_temp;
            t = t * 256 + off;
            if (t < 1)
                t = 1;
            if (t > 64'sd16777215)
                t = 64'sd16777215;
            s.raw_temperature = t[23:0];
        end
        return s;
    endfunction

    function automatic dir_row_t row(bit load, psc_cfg_t cal, logic [23:0] p,
                                     logic [23:0] t, bit known, psc_result_t want);
        dir_row_t r;
        r.load  = load;
        r.cal   = cal;
        r.smp   = {p, t};
        r.known = known;
        r.want  = want;
        return r;
    endfunction

    task automatic put_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
    endtask

    task automatic apply_cal(psc_cfg_t c);
        put_reg($urandom_range(1) ? REG_SPARE_LO : REG_SPARE_HI, 16'($urandom));
        put_reg(REG_SENS_BASE, c.sens_base);
        put_reg(REG_OFFSET_BASE, c.offset_base);
        put_reg(REG_SENS_TEMP_COEFF, c.sens_temp_coeff);
        put_reg(REG_OFFSET_TEMP_COEFF, c.offset_temp_coeff);
        put_reg(REG_REFERENCE_TEMP, c.reference_temp);
        put_reg(REG_TEMP_SLOPE, c.temp_slope);
        cfg_write <= 1'b0;
        cal_model = c;
    endtask

    task automatic send(psc_sample_t s, bit known, psc_result_t want, int idle_pct);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start        <= 1'b1;
        sample       <= s;
        fixed_valid  <= known;
        fixed_result <= want;
        do @(posedge clk); while (busy);
    endtask

    // Waits until the pipeline has emptied out.
    task automatic settle();
        start <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (PSC_LATENCY + 2) @(posedge clk);
    endtask

    // Result checking, transaction capture and the watchdog share one process so
    // that queue updates within a time step keep a fixed order.
    always @(posedge clk)
    begin
        psc_result_t want;
        if (rst_n)
        begin
            if (done)
            begin
                if (pending_results.size() == 0)
                begin
                    mismatches = mismatches + 1;
                    if (mismatches <= REPORT_LIMIT)
                        $display("unexpected result: temp %0d pressure %0d err %0b",
                                 result.temp_centi, result.pressure_centi,
                                 result.error_flag);
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (result.temp_centi !== want.temp_centi ||
                        result.pressure_centi !== want.pressure_centi ||
                        result.error_flag !== want.error_flag)
                    begin
                        mismatches = mismatches + 1;
                        if (mismatches <= REPORT_LIMIT)
                            $display("result mismatch: temp %0d/%0d pressure %0d/%0d err %0b/%0b",
                                     want.temp_centi, result.temp_centi,
                                     want.pressure_centi, result.pressure_centi,
                                     want.error_flag, result.error_flag);
                    end
                end
            end
            if (start && !busy)
                pending_results.push_back(fixed_valid ? fixed_result
                                                      : compensate(sample, cal_model));
            if (done || (start && !busy))
                stall_cycles = 0;
            else
            begin
                stall_cycles = stall_cycles + 1;
                if (stall_cycles >= WATCHDOG_LIMIT)
                begin
                    $display("end of test: mismatches");
                    $finish;
                end
            end
        end
    end

    initial
    begin
        dir_row_t  directed_rows [$];
        cal_kind_t phase_kind [PHASE_COUNT];
        int        phase_idle [PHASE_COUNT];
        psc_cfg_t  ones;

        ones       = '1;
        phase_kind = '{CAL_RANDOM, CAL_NOMINAL, CAL_MIXED, CAL_ALL_ONES,
                       CAL_JITTER, CAL_ALL_ZERO, CAL_RANDOM};
        phase_idle = '{0, 70, 11, 0, 70, 11, 0};

        // Calibration still at its reset value: offset and sensitivity are zero.
        directed_rows.push_back(row(0, '0, 24'd1, 24'd1, 1, RES_IDLE_CAL));
        directed_rows.push_back(row(0, '0, 24'hFFFFFF, 24'd1, 1, RES_IDLE_CAL));
        directed_rows.push_back(row(0, '0, 24'hFFFFFF, 24'hFFFFFF, 1, RES_IDLE_CAL_MAX));
        directed_rows.push_back(row(0, '0, 24'd0, 24'd8077636, 1, RES_ZERO_READING));
        directed_rows.push_back(row(0, '0, 24'd6465444, 24'd0, 1, RES_ZERO_READING));
        directed_rows.push_back(row(0, '0, 24'd0, 24'd0, 1, RES_ZERO_READING));
        // Nominal calibration: warm, cold, frozen and the exact reference point.
        directed_rows.push_back(row(1, CAL_TYPICAL, 24'd6465444, 24'd8077636, 0, '0));
        directed_rows.push_back(row(0, '0, 24'd6465444, 24'd8000000, 0, '0));
        directed_rows.push_back(row(0, '0, 24'd6465444, 24'd1, 0, '0));
        directed_rows.push_back(row(0, '0, 24'hFFFFFF, 24'hFFFFFF, 0, '0));
        directed_rows.push_back(row(0, '0, 24'd1, 24'd1, 0, '0));
        directed_rows.push_back(row(0, '0, 24'hFFFFFF, 24'd8566784, 0, '0));
        directed_rows.push_back(row(0, '0, 24'hFFFFFF, 24'd0, 1, RES_ZERO_READING));
        // All calibration words at their maximum.
        directed_rows.push_back(row(1, ones, 24'hFFFFFF, 24'd1, 0, '0));
        directed_rows.push_back(row(0, '0, 24'd1, 24'hFFFFFF, 0, '0));
        directed_rows.push_back(row(0, '0, 24'hFFFFFF, 24'hFFFFFF, 0, '0));
        directed_rows.push_back(row(0, '0, 24'hAAAAAA, 24'h555555, 0, '0));
        directed_rows.push_back(row(0, '0, 24'h555555, 24'hAAAAAA, 0, '0));
        directed_rows.push_back(row(0, '0, 24'd0, 24'hFFFFFF, 1, RES_ZERO_READING));

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].load)
            begin
                settle();
                apply_cal(directed_rows[i].cal);
            end
            send(directed_rows[i].smp, directed_rows[i].known, directed_rows[i].want, 0);
        end

        for (int ph = 0; ph < PHASE_COUNT; ph++)
        begin
            settle();
            apply_cal(pick_cal(phase_kind[ph]));
            repeat (ITEMS_PER_PHASE)
                send(draw_sample(cal_model), 0, '0, phase_idle[ph]);
        end

        settle();
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/psc_pkg.sv
sv/psc_front.sv
sv/psc_press.sv
sv/pressure_sensor_compensation.sv
verif/tb.sv
